### design/assert_macros.svh
// Assertion helpers shared by the RTL. Every check runs on the rising edge of clk
// and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that prop holds at every clock edge outside reset.
`define LLBA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that cons holds at every edge at which ante holds.
`define LLBA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

### design/llba_pkg.sv
`default_nettype none
package llba_pkg;

	localparam int MAX_BINS   = 16;
	localparam int MAX_ITEMS  = 65536;
	localparam int BIN_W      = $clog2(MAX_BINS);
	localparam int NB_W       = 5;
	localparam int LOAD_W     = 32;
	localparam int WEIGHT_W   = 16;
	localparam int CNT_W      = 17;
	localparam int CFG_W      = 32;
	localparam int REG_IDX_W  = 2;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 8;

	localparam logic [REG_IDX_W-1:0] REG_NUM_BINS   = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_MAX_SPREAD = REG_IDX_W'(1);

	// One entry of the bin memory.
	typedef struct packed {
		logic [CNT_W-1:0]  last;
		logic [LOAD_W-1:0] load;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             load_item;
		logic             rd_en;
		logic [BIN_W-1:0] rd_addr;
		logic             rd_srch;
		logic             rd_first;
		logic             wr_en;
		logic             spread;
		logic             out_load;
		logic             clear;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [BIN_W-1:0] srch_first;
		logic [BIN_W-1:0] srch_last;
		logic [BIN_W-1:0] vrd_last;
		logic             last_item;
	} status_t;

endpackage
`default_nettype wire

### design/llba_ram.sv
`default_nettype none
module llba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                        wr_data,
	input  wire logic                                    rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

### design/llba_dp.sv
`default_nettype none
module llba_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [llba_pkg::REG_IDX_W-1:0]    cfg_index,
	input  wire logic [llba_pkg::CFG_W-1:0]        cfg_wdata,
	input  wire logic [llba_pkg::IN_DATA_W-1:0]    s_tdata,
	input  wire logic                              s_tlast,
	input  wire llba_pkg::cmd_t                    cmd,
	output llba_pkg::status_t                      status,
	output logic      [llba_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                                   m_tlast,
	output logic                                   m_tuser
);

	logic [llba_pkg::NB_W-1:0]     num_bins_q;
	logic [llba_pkg::LOAD_W-1:0]   max_spread_q;
	logic [llba_pkg::WEIGHT_W-1:0] w_q;
	logic                          last_q;
	logic [llba_pkg::NB_W-1:0]     nb_q;
	logic [llba_pkg::CNT_W-1:0]    idx_q;
	logic [llba_pkg::CNT_W-1:0]    cnt_q;
	logic [llba_pkg::MAX_BINS-1:0] used_q;
	logic [llba_pkg::NB_W-1:0]     nb_clamp;
	logic                          idx_lt;

	logic                          srch_s1;
	logic                          vrd_s1;
	logic                          first_s1;
	logic                          rd_used_s1;
	logic [llba_pkg::BIN_W-1:0]    addr_s1;

	logic [llba_pkg::ENTRY_W-1:0]  rd_raw;
	llba_pkg::entry_t              rd_ent;
	llba_pkg::entry_t              wr_ent;
	logic [llba_pkg::LOAD_W-1:0]   eff_load;
	logic                          older;
	logic                          take;

	logic [llba_pkg::LOAD_W-1:0]   best_load_q;
	logic [llba_pkg::CNT_W-1:0]    best_last_q;
	logic                          best_used_q;
	logic [llba_pkg::BIN_W-1:0]    pick_q;
	logic [llba_pkg::LOAD_W:0]     sum;
	logic [llba_pkg::LOAD_W-1:0]   lo_q;
	logic [llba_pkg::LOAD_W-1:0]   hi_q;
	logic                          bal_q;
	logic [llba_pkg::NB_W-1:0]     bin_q;
	logic                          done_q;
	logic                          balanced_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_bins_q   <= llba_pkg::NB_W'(1);
			max_spread_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				llba_pkg::REG_NUM_BINS:   num_bins_q   <= cfg_wdata[llba_pkg::NB_W-1:0];
				llba_pkg::REG_MAX_SPREAD: max_spread_q <= cfg_wdata[llba_pkg::LOAD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (num_bins_q == '0) begin
			nb_clamp = llba_pkg::NB_W'(1);
		end else if (num_bins_q > llba_pkg::NB_W'(llba_pkg::MAX_BINS)) begin
			nb_clamp = llba_pkg::NB_W'(llba_pkg::MAX_BINS);
		end else begin
			nb_clamp = num_bins_q;
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			w_q    <= s_tdata[llba_pkg::WEIGHT_W-1:0];
			last_q <= s_tlast;
			nb_q   <= nb_clamp;
			idx_q  <= cnt_q;
		end
	end

	assign idx_lt            = idx_q < llba_pkg::CNT_W'(nb_q);
	assign status.vrd_last   = llba_pkg::BIN_W'(nb_q - llba_pkg::NB_W'(1));
	assign status.srch_first = idx_lt ? idx_q[llba_pkg::BIN_W-1:0] : '0;
	assign status.srch_last  = idx_lt ? idx_q[llba_pkg::BIN_W-1:0] : status.vrd_last;
	assign status.last_item  = last_q;

	// Used bits double as valid bits of the bin memory; the item counter saturates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.clear) begin
			used_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.wr_en) begin
			used_q[pick_q] <= 1'b1;
			if (cnt_q < llba_pkg::CNT_W'(llba_pkg::MAX_ITEMS)) begin
				cnt_q <= cnt_q + llba_pkg::CNT_W'(1);
			end
		end
	end

	assign sum = (llba_pkg::LOAD_W + 1)'(best_load_q) + (llba_pkg::LOAD_W + 1)'(w_q);
	assign wr_ent.load = sum[llba_pkg::LOAD_W] ? '1 : sum[llba_pkg::LOAD_W-1:0];
	assign wr_ent.last = idx_q;

	llba_ram #(
		.WIDTH(llba_pkg::ENTRY_W),
		.DEPTH(llba_pkg::MAX_BINS)
	) u_bins (
		.clk    (clk),
		.wr_en  (cmd.wr_en),
		.wr_addr(pick_q),
		.wr_data(wr_ent),
		.rd_en  (cmd.rd_en),
		.rd_addr(cmd.rd_addr),
		.rd_data(rd_raw)
	);

	assign rd_ent = rd_raw;

	// Read pipeline stage, aligned with the registered memory output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srch_s1 <= 1'b0;
			vrd_s1  <= 1'b0;
		end else begin
			srch_s1 <= cmd.rd_en && cmd.rd_srch;
			vrd_s1  <= cmd.rd_en && !cmd.rd_srch;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			first_s1   <= cmd.rd_first;
			addr_s1    <= cmd.rd_addr;
			rd_used_s1 <= used_q[cmd.rd_addr];
		end
	end

	assign eff_load = rd_used_s1 ? rd_ent.load : '0;
	// A never-assigned bin is older than any assigned one.
	assign older    = rd_used_s1 ? (best_used_q && (rd_ent.last < best_last_q)) : best_used_q;
	assign take     = first_s1 || (eff_load < best_load_q)
	                  || ((eff_load == best_load_q) && older);

	always_ff @(posedge clk) begin
		if (srch_s1 && take) begin
			best_load_q <= eff_load;
			best_last_q <= rd_ent.last;
			best_used_q <= rd_used_s1;
			pick_q      <= addr_s1;
		end
		if (vrd_s1) begin
			if (first_s1 || (eff_load < lo_q)) begin
				lo_q <= eff_load;
			end
			if (first_s1 || (eff_load > hi_q)) begin
				hi_q <= eff_load;
			end
		end
		if (cmd.spread) begin
			bal_q <= (hi_q - lo_q) <= max_spread_q;
		end
		if (cmd.out_load) begin
			bin_q      <= llba_pkg::NB_W'(pick_q) + llba_pkg::NB_W'(1);
			done_q     <= last_q;
			balanced_q <= last_q && bal_q;
		end
	end

	assign m_tdata = {(llba_pkg::OUT_DATA_W - llba_pkg::NB_W)'(0), bin_q};
	assign m_tlast = done_q;
	assign m_tuser = balanced_q;

endmodule
`default_nettype wire

### design/llba_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module llba_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	input  wire llba_pkg::status_t status,
	output llba_pkg::cmd_t         cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_SRCH = 3'd2;
	localparam logic [2:0] ST_SDRN = 3'd3;
	localparam logic [2:0] ST_UPD  = 3'd4;
	localparam logic [2:0] ST_VERD = 3'd5;
	localparam logic [2:0] ST_VDRN = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;

	logic [2:0]                 state_q;
	logic [2:0]                 state_d;
	logic [llba_pkg::BIN_W-1:0] a_q;
	logic [llba_pkg::BIN_W-1:0] a_d;
	logic                       out_valid_q;
	logic                       out_free;
	logic                       spread_q;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		a_d          = a_q;
		cmd          = '0;
		cmd.rd_addr  = a_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_PREP;
				end
			end
			ST_PREP: begin
				a_d     = status.srch_first;
				state_d = ST_SRCH;
			end
			ST_SRCH: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_srch  = 1'b1;
				cmd.rd_first = (a_q == status.srch_first);
				if (a_q == status.srch_last) begin
					state_d = ST_SDRN;
				end else begin
					a_d = a_q + llba_pkg::BIN_W'(1);
				end
			end
			ST_SDRN: begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.wr_en = 1'b1;
				a_d       = '0;
				state_d   = status.last_item ? ST_VERD : ST_FIN;
			end
			ST_VERD: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_first = (a_q == '0);
				if (a_q == status.vrd_last) begin
					state_d = ST_VDRN;
				end else begin
					a_d = a_q + llba_pkg::BIN_W'(1);
				end
			end
			ST_VDRN: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!spread_q && out_free) begin
					cmd.out_load = 1'b1;
					cmd.clear    = status.last_item;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		// The spread compare runs in the first cycle of ST_FIN after a verdict scan.
		cmd.spread = spread_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			a_q         <= '0;
			out_valid_q <= 1'b0;
			spread_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			a_q      <= a_d;
			spread_q <= (state_q == ST_VDRN);
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`LLBA_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid_q || m_tready, "result overwritten before it was taken")
	`LLBA_ASSERT_IMP(a_write_after_search, cmd.wr_en, $past(state_q == ST_SDRN), "bin memory written outside the update step")
	`LLBA_ASSERT_IMP(a_scan_in_range, state_q == ST_SRCH, a_q <= status.srch_last, "search address ran past its end")

endmodule
`default_nettype wire

### design/least_loaded_bin_assigner.sv
// Greedy least-loaded bin assigner. Each request on the s_ stream carries an item
// weight; the block answers with exactly one result on the m_ stream, giving the bin
// (numbered from 1) that received the item. Within a set the first num_bins items go
// to bins 1..num_bins in order, and every later item goes to the bin with the smallest
// running load, ties going to the bin whose most recent assignment is oldest. On the
// request marked by s_tlast the result carries m_tlast, and m_tuser tells whether the
// heaviest minus the lightest load over the bins in use is at most max_spread; after
// it all set state clears. Items are handled one at a time: s_tready stays low from
// the acceptance of an item until its search over n bins and its update are done
// and the result register is free (n is 1 while the first num_bins items of a set
// arrive, num_bins afterwards). The last item of a set also waits for the verdict
// scan. The search and the verdict scan walk the bin memory, which has a single
// read port, one bin per cycle. The user writes configuration through cfg_we,
// cfg_index and cfg_wdata only while the block is idle; the block does not enforce
// it. Index 0 is num_bins, index 1 is max_spread.
`default_nettype none
module least_loaded_bin_assigner (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Configuration write port.
	input  wire logic                            cfg_we,
	input  wire logic [llba_pkg::REG_IDX_W-1:0]  cfg_index,
	input  wire logic [llba_pkg::CFG_W-1:0]      cfg_wdata,
	// Item requests.
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [llba_pkg::IN_DATA_W-1:0]  s_tdata,  // [15:0] weight
	input  wire logic                            s_tlast,  // last_item
	// Results.
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic      [llba_pkg::OUT_DATA_W-1:0] m_tdata,  // [4:0] bin_number, [7:5] zero
	output logic                                 m_tlast,  // set_done
	output logic                                 m_tuser   // [0] balanced
);

	// The controller sequences the search, update and verdict steps; the datapath
	// holds the bin memory, the best-bin registers and the output register.
	llba_pkg::cmd_t    cmd;
	llba_pkg::status_t status;

	llba_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.status  (status),
		.cmd     (cmd)
	);

	llba_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.cmd      (cmd),
		.status   (status),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

### tb/bin_assignment_checker.sv
module bin_assignment_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [llba_pkg::REG_IDX_W-1:0]  cfg_index,
	input  wire logic [llba_pkg::CFG_W-1:0]      cfg_wdata,
	input  wire logic                            s_tvalid,
	input  wire logic                            s_tready,
	input  wire logic [llba_pkg::IN_DATA_W-1:0]  s_tdata,  // [15:0] weight
	input  wire logic                            s_tlast,  // last_item
	input  wire logic                            m_tvalid,
	input  wire logic                            m_tready,
	input  wire logic [llba_pkg::OUT_DATA_W-1:0] m_tdata,  // [4:0] bin_number, [7:5] zero
	input  wire logic                            m_tlast,  // set_done
	input  wire logic                            m_tuser,  // [0] balanced
	output int                                   fail_count,
	output int                                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [llba_pkg::NB_W-1:0] bin_number;
		logic                      set_done;
		logic                      balanced;
	} placement_t;

	// Running set state, mirrored from the block's behavior.
	logic [llba_pkg::LOAD_W-1:0] load_of [llba_pkg::MAX_BINS];
	logic [llba_pkg::CNT_W-1:0]  stamp_of [llba_pkg::MAX_BINS];
	logic                        taken [llba_pkg::MAX_BINS];
	logic [llba_pkg::CNT_W-1:0]  seq_count;
	logic [llba_pkg::NB_W-1:0]   num_bins;
	logic [llba_pkg::LOAD_W-1:0] max_spread;

	placement_t expected_placements[$];
	placement_t oldest;
	int         results_seen;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	function automatic void clear_bins();
		for (int k = 0; k < llba_pkg::MAX_BINS; k++) begin
			load_of[k] = '0;
			stamp_of[k] = '0;
			taken[k] = 1'b0;
		end
		seq_count = '0;
	endfunction

	// A bin never assigned in this set beats any assigned one on equal load.
	function automatic bit ages_first(int a, int b);
		if (!taken[a])
			return taken[b];
		if (!taken[b])
			return 1'b0;
		return stamp_of[a] < stamp_of[b];
	endfunction

	function automatic placement_t place_item(logic [llba_pkg::WEIGHT_W-1:0] weight,
		logic closes);
		placement_t                  r;
		int                          active;
		int                          pick;
		logic [llba_pkg::LOAD_W-1:0] lo;
		logic [llba_pkg::LOAD_W-1:0] hi;
		if (num_bins == 0)
			active = 1;
		else if (num_bins > llba_pkg::MAX_BINS)
			active = llba_pkg::MAX_BINS;
		else
			active = int'(num_bins);
		pick = 0;
		if (seq_count < active) begin
			pick = int'(seq_count);
		end else begin
			for (int k = 1; k < active; k++) begin
				if (load_of[k] < load_of[pick] ||
				    (load_of[k] == load_of[pick] && ages_first(k, pick)))
					pick = k;
			end
		end
		if (load_of[pick] > {llba_pkg::LOAD_W{1'b1}} - llba_pkg::LOAD_W'(weight))
			load_of[pick] = '1;
		else
			load_of[pick] = load_of[pick] + llba_pkg::LOAD_W'(weight);
		stamp_of[pick] = seq_count;
		taken[pick] = 1'b1;
		if (seq_count < llba_pkg::MAX_ITEMS)
			seq_count = seq_count + 1'b1;
		r.bin_number = llba_pkg::NB_W'(pick + 1);
		r.set_done = 1'b0;
		r.balanced = 1'b0;
		if (closes) begin
			lo = load_of[0];
			hi = load_of[0];
			for (int k = 1; k < active; k++) begin
				if (load_of[k] < lo)
					lo = load_of[k];
				if (load_of[k] > hi)
					hi = load_of[k];
			end
			r.set_done = 1'b1;
			r.balanced = (hi - lo <= max_spread);
			clear_bins();
		end
		return r;
	endfunction

	task automatic report(string msg);
		fail_count++;
		$display("%0t ns: result %0d: %s", $time, results_seen, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_bins();
			num_bins = llba_pkg::NB_W'(1);
			max_spread = '0;
			expected_placements.delete();
			results_seen = 0;
			pending = 0;
		end else begin
			// Results are matched before new requests are booked, so a result
			// that beats its own request is caught.
			if (m_tvalid && m_tready) begin
				if (expected_placements.size() == 0) begin
					report($sformatf("result with no request waiting, bin %0d",
						m_tdata[llba_pkg::NB_W-1:0]));
				end else begin
					oldest = expected_placements.pop_front();
					if (m_tdata[llba_pkg::NB_W-1:0] !== oldest.bin_number)
						report($sformatf("bin_number is %0d, expected %0d",
							m_tdata[llba_pkg::NB_W-1:0], oldest.bin_number));
					if (m_tdata[llba_pkg::OUT_DATA_W-1:llba_pkg::NB_W] !== '0)
						report($sformatf("tdata padding is %b, expected zero",
							m_tdata[llba_pkg::OUT_DATA_W-1:llba_pkg::NB_W]));
					if (m_tlast !== oldest.set_done)
						report($sformatf("set_done is %b, expected %b",
							m_tlast, oldest.set_done));
					if (m_tuser !== oldest.balanced)
						report($sformatf("balanced is %b, expected %b",
							m_tuser, oldest.balanced));
				end
				results_seen++;
			end
			if (cfg_we) begin
				case (cfg_index)
					llba_pkg::REG_NUM_BINS:
						num_bins = cfg_wdata[llba_pkg::NB_W-1:0];
					llba_pkg::REG_MAX_SPREAD:
						max_spread = cfg_wdata[llba_pkg::LOAD_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_placements = {expected_placements,
					place_item(s_tdata[llba_pkg::WEIGHT_W-1:0], s_tlast)};
			pending = expected_placements.size();
		end
	end

endmodule

### tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// The block is idle once all results are in; configuration writes still wait
	// this long after that, a margin well past a full 16-bin scan.
	localparam int SETTLE_CYCLES = 48;
	// Length of the deliberate receiver hold-off that backs the block up.
	localparam int LONG_STALL = 300;
	// Cycles with no request accepted on either stream before the run is abandoned.
	localparam int WATCHDOG_LIMIT = 5000;
	// Quiet time after the last result, to catch stray extra results.
	localparam int TAIL_CYCLES = 64;
	// Items offered back to back while the receiver holds off.
	localparam int STALL_SET_ITEMS = 8;

	// Register indexes past the end of the map; writes to them must be ignored.
	localparam logic [llba_pkg::REG_IDX_W-1:0] REG_UNMAPPED_A = llba_pkg::REG_IDX_W'(2);
	localparam logic [llba_pkg::REG_IDX_W-1:0] REG_UNMAPPED_B = llba_pkg::REG_IDX_W'(3);

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [llba_pkg::REG_IDX_W-1:0]  cfg_index;
	logic [llba_pkg::CFG_W-1:0]      cfg_wdata;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [llba_pkg::IN_DATA_W-1:0]  s_tdata;
	logic                            s_tlast;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [llba_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                            m_tlast;
	logic                            m_tuser;

	int fail_count;
	int pending;

	// Idle percentages for each side; changed between phases of the run.
	int snd_idle;
	int rcv_idle;
	// The stimulus asks for a receiver hold-off by bumping stall_reqs; the
	// receiver process notices the change and counts the stall out by itself.
	int stall_reqs = 0;
	int stall_served = 0;
	int stall_left = 0;

	int quiet_cycles;
	int items_sent = 0;
	// Number of bins the block is currently using, after clamping.
	int nb_now = 1;

	least_loaded_bin_assigner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	bin_assignment_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: drives m_tready at every falling edge. Outside a requested hold-off
	// it drops ready at random according to rcv_idle.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_reqs != stall_served) begin
				stall_served = stall_reqs;
				stall_left = LONG_STALL;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rcv_idle);
			end
		end
	end

	// Watchdog: a long stretch with no request accepted on either stream means
	// the block has hung, and the run ends as a failure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("least_loaded_bin_assigner verification failed");
				$finish;
			end
		end
	end

	function automatic int clamp_bins(logic [llba_pkg::NB_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > llba_pkg::MAX_BINS)
			return llba_pkg::MAX_BINS;
		return int'(v);
	endfunction

	// Weights lean toward zero, the maximum and tiny values, so that equal loads
	// and the age tie-break come up often.
	function automatic logic [llba_pkg::WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2, 3: return llba_pkg::WEIGHT_W'($urandom_range(15));
			default: return llba_pkg::WEIGHT_W'($urandom);
		endcase
	endfunction

	// A num_bins write word: random upper bits, which the block must discard,
	// over a bin count that now and then lands on zero or past the maximum.
	function automatic logic [llba_pkg::CFG_W-1:0] pick_bins_word();
		logic [llba_pkg::CFG_W-1:0] word;
		word = llba_pkg::CFG_W'($urandom);
		case ($urandom_range(9))
			0: word[llba_pkg::NB_W-1:0] = '0;
			1: word[llba_pkg::NB_W-1:0] =
				llba_pkg::NB_W'($urandom_range(llba_pkg::MAX_BINS + 1, 31));
			2: word[llba_pkg::NB_W-1:0] = llba_pkg::NB_W'(llba_pkg::MAX_BINS);
			3: word[llba_pkg::NB_W-1:0] = llba_pkg::NB_W'(1);
			default: word[llba_pkg::NB_W-1:0] =
				llba_pkg::NB_W'($urandom_range(1, llba_pkg::MAX_BINS));
		endcase
		return word;
	endfunction

	function automatic logic [llba_pkg::CFG_W-1:0] pick_spread();
		case ($urandom_range(4))
			0: return '0;
			1: return '1;
			2: return llba_pkg::CFG_W'($urandom_range(64));
			3: return llba_pkg::CFG_W'($urandom_range(300000));
			default: return llba_pkg::CFG_W'($urandom);
		endcase
	endfunction

	// Offers one item request, with random idle cycles in front of it, and holds
	// it until the block takes it. Valid stays high when the next item follows
	// at once.
	task automatic send_item(input logic [llba_pkg::WEIGHT_W-1:0] weight,
		input logic closes);
		@(negedge clk);
		while ($urandom_range(99) < snd_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= weight;
		s_tlast <= closes;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	// Stops offering and waits until every expected result has come back.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending == 0);
	endtask

	// Registers are only written with the block idle: all results in, plus a
	// settling margin.
	task automatic write_reg(input logic [llba_pkg::REG_IDX_W-1:0] idx,
		input logic [llba_pkg::CFG_W-1:0] value);
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == llba_pkg::REG_NUM_BINS)
			nb_now = clamp_bins(value[llba_pkg::NB_W-1:0]);
	endtask

	// One set of random items. Once in a while the bin count changes in the
	// middle of the set, which exercises never-assigned bins joining the search
	// and loaded bins dropping out of it.
	task automatic run_set(input int len);
		for (int i = 0; i < len; i++) begin
			if (i > 0 && $urandom_range(24) == 0)
				write_reg(llba_pkg::REG_NUM_BINS, pick_bins_word());
			send_item(pick_weight(), i == len - 1);
		end
	endtask

	// Random sets until about count more items have gone in. Most sets run well
	// past the first num_bins items so the least-loaded search does the work;
	// some are short sets that close before every bin has an item.
	task automatic run_random(input int count);
		int target;
		int len;
		target = items_sent + count;
		while (items_sent < target) begin
			if ($urandom_range(1))
				write_reg(llba_pkg::REG_NUM_BINS, pick_bins_word());
			if ($urandom_range(2) == 0)
				write_reg(llba_pkg::REG_MAX_SPREAD, pick_spread());
			if ($urandom_range(15) == 0)
				write_reg($urandom_range(1) ? REG_UNMAPPED_A : REG_UNMAPPED_B,
					llba_pkg::CFG_W'($urandom));
			if ($urandom_range(9) == 0)
				len = $urandom_range(1, nb_now);
			else
				len = $urandom_range(nb_now, 3 * nb_now + 4);
			run_set(len);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = llba_pkg::REG_NUM_BINS;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		snd_idle = 34;
		rcv_idle = 57;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. Reset settings first: one bin, zero spread allowed, with
		// the weight extremes.
		send_item(16'h0000, 1'b0);
		send_item(16'hFFFF, 1'b1);

		// Four bins with equal loads: the zero-weight items that follow go to the
		// bins whose last assignment is oldest, and the verdict is balanced.
		write_reg(llba_pkg::REG_NUM_BINS, llba_pkg::CFG_W'(4));
		repeat (4) send_item(16'd10, 1'b0);
		send_item(16'd0, 1'b0);
		send_item(16'd0, 1'b1);

		// Short set: two bins stay empty and count as zero load. Unbalanced at
		// zero spread, balanced once the spread equals the gap exactly.
		send_item(16'd7, 1'b0);
		send_item(16'd9, 1'b1);
		write_reg(llba_pkg::REG_MAX_SPREAD, llba_pkg::CFG_W'(9));
		send_item(16'd7, 1'b0);
		send_item(16'd9, 1'b1);

		// A bin count of zero behaves as one bin.
		write_reg(llba_pkg::REG_NUM_BINS, llba_pkg::CFG_W'(0));
		send_item(16'd3, 1'b0);
		send_item(16'd5, 1'b1);

		// A bin count past the maximum behaves as the maximum.
		write_reg(llba_pkg::REG_NUM_BINS, llba_pkg::CFG_W'(31));
		send_item(16'hFFFF, 1'b0);
		send_item(16'd1, 1'b0);
		send_item(16'd0, 1'b1);

		// Writes to indexes past the register map change nothing.
		write_reg(REG_UNMAPPED_A, '1);
		write_reg(REG_UNMAPPED_B, '0);

		// Shrinking the bin count mid-set hides bin 3 from the search; growing it
		// again brings in bin 4, never assigned, with zero load.
		write_reg(llba_pkg::REG_NUM_BINS, llba_pkg::CFG_W'(6));
		send_item(16'd100, 1'b0);
		send_item(16'd200, 1'b0);
		send_item(16'd300, 1'b0);
		write_reg(llba_pkg::REG_NUM_BINS, llba_pkg::CFG_W'(2));
		send_item(16'd50, 1'b0);
		write_reg(llba_pkg::REG_NUM_BINS, llba_pkg::CFG_W'(4));
		send_item(16'd1, 1'b0);
		send_item(16'd0, 1'b1);

		// Random part, first phase: sender idles less than the receiver. Midway
		// the receiver holds off for a long stretch while a set of items keeps
		// coming, so the block fills up and stalls its input.
		run_random(90);
		stall_reqs++;
		for (int i = 0; i < STALL_SET_ITEMS; i++)
			send_item(pick_weight(), i == STALL_SET_ITEMS - 1);
		run_random(100);

		// Second phase with the idle rates swapped. Midway the sender pauses
		// until every outstanding result is back.
		snd_idle = 57;
		rcv_idle = 34;
		run_random(90);
		drain_results();
		run_random(100);

		// Third phase: no idling on either side.
		snd_idle = 0;
		rcv_idle = 0;
		run_random(170);

		// A closing set that starts from a clean state.
		write_reg(llba_pkg::REG_NUM_BINS, llba_pkg::CFG_W'(2));
		write_reg(llba_pkg::REG_MAX_SPREAD, '0);
		send_item(16'd4, 1'b0);
		send_item(16'd4, 1'b0);
		send_item(16'd2, 1'b1);

		drain_results();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("least_loaded_bin_assigner verification clean");
		else
			$display("least_loaded_bin_assigner verification failed");
		$finish;
	end

endmodule
